FILE: src/hms_pkg.sv
// Shared types, constants and functions of the HMAC MD5 / SHA-1 engine.
// Used by hms_ctrl, hms_datapath and hmac_md5_sha1_engine_top; no dependencies.
`timescale 1ns / 1ps

package hms_pkg;

  localparam int unsigned BLOCK_BYTES = 64;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] MARK_BYTE = 8'h80;

  localparam logic [6:0] MD5_DIGEST_BYTES  = 7'd16;
  localparam logic [6:0] SHA1_DIGEST_BYTES = 7'd20;
  localparam logic [6:0] MD5_LAST_ROUND    = 7'd63;
  localparam logic [6:0] SHA1_LAST_ROUND   = 7'd79;
  localparam logic [6:0] MD5_LAST_WORD     = 7'd3;
  localparam logic [6:0] SHA1_LAST_WORD    = 7'd4;

  localparam logic [5:0] PTR_LAST   = 6'd63;
  localparam logic [5:0] PTR_LENGTH = 6'd56;
  localparam logic [6:0] KEY_FULL   = 7'd64;

  localparam logic PH_KEY = 1'b0;
  localparam logic PH_MSG = 1'b1;
  localparam logic OP_KEY = 1'b0;
  localparam logic OP_MSG = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
  } hms_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } hms_out_t;

  typedef logic [4:0][31:0] hms_words_t;

  typedef enum logic [2:0] {
    SRC_IN    = 3'd0,
    SRC_KEY   = 3'd1,
    SRC_MARK  = 3'd2,
    SRC_ZERO  = 3'd3,
    SRC_LEN   = 3'd4,
    SRC_INNER = 3'd5
  } hms_src_t;

  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_IN   = 2'd1,
    PAD_OUT  = 2'd2
  } hms_pad_t;

  typedef struct packed {
    logic       sha;
    logic       start;
    logic       wr_byte;
    logic       count_len;
    hms_src_t   src;
    hms_pad_t   pad;
    logic [6:0] idx;
    logic [6:0] key_count;
    logic [7:0] in_byte;
    logic       key_wr;
    logic       key_wr_dig;
    logic [5:0] key_addr;
    logic       comp_init;
    logic       comp_round;
    logic       comp_add;
    logic [6:0] rnd;
    logic       save_inner;
  } hms_cmd_t;

  typedef struct packed {
    logic [5:0] ptr;
  } hms_stat_t;

  function automatic logic [31:0] bswap(input logic [31:0] w);
    bswap = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Digest byte i of a chain value, in the byte order of the selected hash.
  function automatic logic [7:0] dig_byte(input hms_words_t w, input logic [4:0] i,
                                          input logic sha);
    logic [31:0] word;
    logic [1:0]  lane;
    word = w[i[4:2]];
    lane = sha ? ~i[1:0] : i[1:0];
    dig_byte = word[{lane, 3'b000} +: 8];
  endfunction

  function automatic logic [4:0] md5_rot(input logic [3:0] i);
    unique case (i)
      4'd0: md5_rot = 5'd7;    4'd1: md5_rot = 5'd12;
      4'd2: md5_rot = 5'd17;   4'd3: md5_rot = 5'd22;
      4'd4: md5_rot = 5'd5;    4'd5: md5_rot = 5'd9;
      4'd6: md5_rot = 5'd14;   4'd7: md5_rot = 5'd20;
      4'd8: md5_rot = 5'd4;    4'd9: md5_rot = 5'd11;
      4'd10: md5_rot = 5'd16;  4'd11: md5_rot = 5'd23;
      4'd12: md5_rot = 5'd6;   4'd13: md5_rot = 5'd10;
      4'd14: md5_rot = 5'd15;  4'd15: md5_rot = 5'd21;
      default: md5_rot = 5'd0;
    endcase
  endfunction

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    unique case (i)
      6'd0: md5_k = 32'hd76aa478;  6'd1: md5_k = 32'he8c7b756;
      6'd2: md5_k = 32'h242070db;  6'd3: md5_k = 32'hc1bdceee;
      6'd4: md5_k = 32'hf57c0faf;  6'd5: md5_k = 32'h4787c62a;
      6'd6: md5_k = 32'ha8304613;  6'd7: md5_k = 32'hfd469501;
      6'd8: md5_k = 32'h698098d8;  6'd9: md5_k = 32'h8b44f7af;
      6'd10: md5_k = 32'hffff5bb1; 6'd11: md5_k = 32'h895cd7be;
      6'd12: md5_k = 32'h6b901122; 6'd13: md5_k = 32'hfd987193;
      6'd14: md5_k = 32'ha679438e; 6'd15: md5_k = 32'h49b40821;
      6'd16: md5_k = 32'hf61e2562; 6'd17: md5_k = 32'hc040b340;
      6'd18: md5_k = 32'h265e5a51; 6'd19: md5_k = 32'he9b6c7aa;
      6'd20: md5_k = 32'hd62f105d; 6'd21: md5_k = 32'h02441453;
      6'd22: md5_k = 32'hd8a1e681; 6'd23: md5_k = 32'he7d3fbc8;
      6'd24: md5_k = 32'h21e1cde6; 6'd25: md5_k = 32'hc33707d6;
      6'd26: md5_k = 32'hf4d50d87; 6'd27: md5_k = 32'h455a14ed;
      6'd28: md5_k = 32'ha9e3e905; 6'd29: md5_k = 32'hfcefa3f8;
      6'd30: md5_k = 32'h676f02d9; 6'd31: md5_k = 32'h8d2a4c8a;
      6'd32: md5_k = 32'hfffa3942; 6'd33: md5_k = 32'h8771f681;
      6'd34: md5_k = 32'h6d9d6122; 6'd35: md5_k = 32'hfde5380c;
      6'd36: md5_k = 32'ha4beea44; 6'd37: md5_k = 32'h4bdecfa9;
      6'd38: md5_k = 32'hf6bb4b60; 6'd39: md5_k = 32'hbebfbc70;
      6'd40: md5_k = 32'h289b7ec6; 6'd41: md5_k = 32'heaa127fa;
      6'd42: md5_k = 32'hd4ef3085; 6'd43: md5_k = 32'h04881d05;
      6'd44: md5_k = 32'hd9d4d039; 6'd45: md5_k = 32'he6db99e5;
      6'd46: md5_k = 32'h1fa27cf8; 6'd47: md5_k = 32'hc4ac5665;
      6'd48: md5_k = 32'hf4292244; 6'd49: md5_k = 32'h432aff97;
      6'd50: md5_k = 32'hab9423a7; 6'd51: md5_k = 32'hfc93a039;
      6'd52: md5_k = 32'h655b59c3; 6'd53: md5_k = 32'h8f0ccc92;
      6'd54: md5_k = 32'hffeff47d; 6'd55: md5_k = 32'h85845dd1;
      6'd56: md5_k = 32'h6fa87e4f; 6'd57: md5_k = 32'hfe2ce6e0;
      6'd58: md5_k = 32'ha3014314; 6'd59: md5_k = 32'h4e0811a1;
      6'd60: md5_k = 32'hf7537e82; 6'd61: md5_k = 32'hbd3af235;
      6'd62: md5_k = 32'h2ad7d2bb; 6'd63: md5_k = 32'heb86d391;
      default: md5_k = 32'h0;
    endcase
  endfunction

endpackage

FILE: src/hmac_md5_sha1_engine_top.sv
// Top level of the HMAC engine over MD5 or SHA-1.
// Instantiates hms_ctrl and hms_datapath; depends on hms_pkg.
`timescale 1ns / 1ps

// Usage:
// Input beats carry one key or message byte each (in_item), with has_data low for
// an empty run and last high on the final beat of a run. Send the key run first,
// then the message run. in_stall is high whenever the engine is busy.
// cfg_data selects the hash (0 MD5, 1 SHA-1); it is taken only while cfg_ready is
// high, which is whenever no item is in flight.
// Filling a 64-byte block adds one compression for MD5 or SHA-1, one round per cycle
// in a single round unit. Closing the key runs the inner pad block, plus one extra
// hash finish when the key was longer than 64 bytes.
// Closing the message runs inner finish, outer pad, digest absorb and outer finish,
// then 4 (MD5) or 5 (SHA-1) result beats on out_item, last_word marking the final
// one. While out_stall is high the current word holds and no new input is taken.
// rst_n is synchronous and active low; after reset the engine is idle, awaits a key
// and uses MD5.

module hmac_md5_sha1_engine_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  hms_pkg::hms_in_t  in_item,
  output logic              in_stall,
  output logic              out_valid,
  output hms_pkg::hms_out_t out_item,
  input  logic              out_stall,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  output logic              cfg_ready
);
  import hms_pkg::*;

  hms_cmd_t    cmd;
  hms_stat_t   stat;
  logic [31:0] dp_word;
  logic        ctrl_last;

  hms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_last  (ctrl_last),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hms_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .word_out (dp_word)
  );

  always_comb begin
    out_item.digest_word = dp_word;
    out_item.last_word   = ctrl_last;
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results are pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("engine not busy after an accepted beat");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_item.last_word) |=> (!out_valid && !in_stall))
    else $error("result beats continue after the final word");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> (!out_valid && !in_stall))
    else $error("configuration open while busy");

endmodule

FILE: src/hms_datapath.sv
// Datapath of the HMAC engine: block buffer, chain value, round logic and key store.
// Driven by hms_ctrl through hms_pkg::hms_cmd_t; depends on hms_pkg.
`timescale 1ns / 1ps

module hms_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  hms_pkg::hms_cmd_t  cmd,
  output hms_pkg::hms_stat_t stat,
  output logic [31:0]        word_out
);
  import hms_pkg::*;

  hms_words_t        chain_r;
  hms_words_t        inner_r;
  logic [31:0]       a_r, b_r, c_r, d_r, e_r;
  logic [15:0][31:0] win_r;
  logic [5:0]        ptr_r;
  logic [63:0]       bitlen_r;
  logic [7:0]        key_mem [BLOCK_BYTES];
  logic [7:0]        key_rd_r;

  logic [7:0]  pad_byte, key_byte, len_byte, src_byte, key_wdata;
  logic [2:0]  len_lane;
  logic [1:0]  md_grp;
  logic [3:0]  md_i, md_g;
  logic [31:0] md_f, md_m, md_sum, md_b;
  logic [4:0]  md_sh;
  logic [63:0] md_dbl;
  logic [31:0] sh_f, sh_k, sh_t, sh_w;
  logic [31:0] out_w;

  always_comb begin
    unique case (cmd.pad)
      PAD_IN:  pad_byte = IPAD_BYTE;
      PAD_OUT: pad_byte = OPAD_BYTE;
      default: pad_byte = 8'h00;
    endcase
    key_byte = ((cmd.idx < cmd.key_count) ? key_rd_r : 8'h00) ^ pad_byte;
    len_lane = cmd.sha ? ~ptr_r[2:0] : ptr_r[2:0];
    len_byte = bitlen_r[{len_lane, 3'b000} +: 8];
    unique case (cmd.src)
      SRC_IN:    src_byte = cmd.in_byte;
      SRC_KEY:   src_byte = key_byte;
      SRC_MARK:  src_byte = MARK_BYTE;
      SRC_LEN:   src_byte = len_byte;
      SRC_INNER: src_byte = dig_byte(inner_r, cmd.idx[4:0], cmd.sha);
      default:   src_byte = 8'h00;
    endcase
    key_wdata = cmd.key_wr_dig ? dig_byte(chain_r, cmd.idx[4:0], cmd.sha) : cmd.in_byte;
  end

  always_comb begin
    md_grp = cmd.rnd[5:4];
    md_i   = cmd.rnd[3:0];
    unique case (md_grp)
      2'd0: begin
        md_f = (b_r & c_r) | (~b_r & d_r);
        md_g = md_i;
      end
      2'd1: begin
        md_f = (d_r & b_r) | (~d_r & c_r);
        md_g = (md_i << 2) + md_i + 4'd1;
      end
      2'd2: begin
        md_f = b_r ^ c_r ^ d_r;
        md_g = (md_i << 1) + md_i + 4'd5;
      end
      default: begin
        md_f = c_r ^ (b_r | ~d_r);
        md_g = (md_i << 3) - md_i;
      end
    endcase
    md_m   = bswap(win_r[md_g]);
    md_sum = a_r + md_f + md5_k(cmd.rnd[5:0]) + md_m;
    md_sh  = md5_rot({md_grp, cmd.rnd[1:0]});
    md_dbl = {md_sum, md_sum} << md_sh;
    md_b   = b_r + md_dbl[63:32];
  end

  always_comb begin
    priority if (cmd.rnd < 7'd20) begin
      sh_f = (b_r & c_r) | (~b_r & d_r);
      sh_k = 32'h5a827999;
    end else if (cmd.rnd < 7'd40) begin
      sh_f = b_r ^ c_r ^ d_r;
      sh_k = 32'h6ed9eba1;
    end else if (cmd.rnd < 7'd60) begin
      sh_f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      sh_k = 32'h8f1bbcdc;
    end else begin
      sh_f = b_r ^ c_r ^ d_r;
      sh_k = 32'hca62c1d6;
    end
    sh_t = {a_r[26:0], a_r[31:27]} + sh_f + e_r + sh_k + win_r[0];
    sh_w = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      bitlen_r <= '0;
    end else if (cmd.start) begin
      ptr_r    <= '0;
      bitlen_r <= '0;
    end else begin
      if (cmd.wr_byte) begin
        ptr_r <= ptr_r + 6'd1;
      end
      if (cmd.count_len) begin
        bitlen_r <= bitlen_r + 64'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      chain_r <= {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
    end else if (cmd.comp_add) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      if (cmd.sha) begin
        chain_r[4] <= chain_r[4] + e_r;
      end
    end
    if (cmd.save_inner) begin
      inner_r <= chain_r;
    end
    if (cmd.comp_init) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.comp_round) begin
      if (cmd.sha) begin
        a_r <= sh_t;
        b_r <= a_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        d_r <= c_r;
        e_r <= d_r;
      end else begin
        a_r <= d_r;
        b_r <= md_b;
        c_r <= b_r;
        d_r <= c_r;
      end
    end
    if (cmd.wr_byte) begin
      win_r[ptr_r[5:2]][{~ptr_r[1:0], 3'b000} +: 8] <= src_byte;
    end else if (cmd.comp_round && cmd.sha) begin
      win_r[14:0] <= win_r[15:1];
      win_r[15]   <= {sh_w[30:0], sh_w[31]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      key_mem[cmd.key_addr] <= key_wdata;
    end
    key_rd_r <= key_mem[cmd.idx[5:0]];
  end

  always_comb begin
    out_w    = chain_r[cmd.idx[2:0]];
    word_out = cmd.sha ? out_w : bswap(out_w);
    stat.ptr = ptr_r;
  end

endmodule

FILE: src/hms_ctrl.sv
// Controller of the HMAC engine: item decode, key and message phases, padding and
// compression sequencing, result beats. Depends on hms_pkg; drives hms_datapath.
`timescale 1ns / 1ps

module hms_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  hms_pkg::hms_in_t   in_item,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_last,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  output logic               cfg_ready,
  input  hms_pkg::hms_stat_t stat,
  output hms_pkg::hms_cmd_t  cmd
);
  import hms_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE       = 18'h00001,
    S_DECODE     = 18'h00002,
    S_ABS_IN     = 18'h00004,
    S_AFTER      = 18'h00008,
    S_PAD_RD     = 18'h00010,
    S_PAD_WR     = 18'h00020,
    S_CINIT      = 18'h00040,
    S_COMP       = 18'h00080,
    S_CADD       = 18'h00100,
    S_FIN_MARK   = 18'h00200,
    S_FIN_ZERO   = 18'h00400,
    S_FIN_LEN    = 18'h00800,
    S_KEYDIG     = 18'h01000,
    S_START_IPAD = 18'h02000,
    S_SET_MSG    = 18'h04000,
    S_SAVE_INNER = 18'h08000,
    S_INNER_ABS  = 18'h10000,
    S_OUT        = 18'h20000
  } hms_state_t;

  hms_state_t state_r, state_nxt;
  hms_state_t loop_ret_r, loop_ret_nxt;
  hms_state_t fin_ret_r, fin_ret_nxt;
  hms_state_t cmp_ret_r, cmp_ret_nxt;
  hms_in_t    item_r, item_nxt;
  hms_pad_t   pad_r, pad_nxt;
  logic       phase_r, phase_nxt;
  logic       long_r, long_nxt;
  logic       sha_r, sha_nxt;
  logic       wrap_r, wrap_nxt;
  logic [6:0] key_count_r, key_count_nxt;
  logic [6:0] idx_r, idx_nxt;
  logic [6:0] rnd_r, rnd_nxt;

  logic [6:0] dig_n, last_word, last_rnd;
  logic       ptr_end;

  always_comb begin
    dig_n     = sha_r ? SHA1_DIGEST_BYTES : MD5_DIGEST_BYTES;
    last_word = sha_r ? SHA1_LAST_WORD : MD5_LAST_WORD;
    last_rnd  = sha_r ? SHA1_LAST_ROUND : MD5_LAST_ROUND;
    ptr_end   = (stat.ptr == PTR_LAST);
  end

  always_comb begin
    state_nxt     = state_r;
    loop_ret_nxt  = loop_ret_r;
    fin_ret_nxt   = fin_ret_r;
    cmp_ret_nxt   = cmp_ret_r;
    item_nxt      = item_r;
    pad_nxt       = pad_r;
    phase_nxt     = phase_r;
    long_nxt      = long_r;
    sha_nxt       = sha_r;
    wrap_nxt      = wrap_r;
    key_count_nxt = key_count_r;
    idx_nxt       = idx_r;
    rnd_nxt       = rnd_r;

    cmd            = '0;
    cmd.sha        = sha_r;
    cmd.src        = SRC_ZERO;
    cmd.pad        = pad_r;
    cmd.idx        = idx_r;
    cmd.key_count  = key_count_r;
    cmd.in_byte    = item_r.data_byte;
    cmd.key_addr   = key_count_r[5:0];
    cmd.rnd        = rnd_r;

    in_stall  = (state_r != S_IDLE);
    cfg_ready = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    out_last  = (idx_r == last_word);

    if (cfg_valid && cfg_ready) begin
      sha_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (phase_r == PH_KEY) begin
          if (item_r.operation != OP_KEY) begin
            state_nxt = S_IDLE;
          end else if (!item_r.has_data) begin
            state_nxt = S_AFTER;
          end else if (long_r) begin
            state_nxt = S_ABS_IN;
          end else if (key_count_r < KEY_FULL) begin
            cmd.key_wr    = 1'b1;
            key_count_nxt = key_count_r + 7'd1;
            state_nxt     = S_AFTER;
          end else begin
            cmd.start    = 1'b1;
            pad_nxt      = PAD_NONE;
            idx_nxt      = '0;
            loop_ret_nxt = S_ABS_IN;
            long_nxt     = 1'b1;
            state_nxt    = S_PAD_RD;
          end
        end else begin
          if (item_r.operation != OP_MSG) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = item_r.has_data ? S_ABS_IN : S_AFTER;
          end
        end
      end
      S_ABS_IN: begin
        cmd.wr_byte   = 1'b1;
        cmd.count_len = 1'b1;
        cmd.src       = SRC_IN;
        if (ptr_end) begin
          cmp_ret_nxt = S_AFTER;
          state_nxt   = S_CINIT;
        end else begin
          state_nxt = item_r.last ? S_AFTER : S_IDLE;
        end
      end
      S_AFTER: begin
        if (!item_r.last) begin
          state_nxt = S_IDLE;
        end else if (phase_r == PH_KEY) begin
          if (long_r) begin
            fin_ret_nxt = S_KEYDIG;
            state_nxt   = S_FIN_MARK;
          end else begin
            state_nxt = S_START_IPAD;
          end
        end else begin
          fin_ret_nxt = S_SAVE_INNER;
          state_nxt   = S_FIN_MARK;
        end
      end
      S_PAD_RD: begin
        state_nxt = S_PAD_WR;
      end
      S_PAD_WR: begin
        cmd.wr_byte   = 1'b1;
        cmd.count_len = 1'b1;
        cmd.src       = SRC_KEY;
        idx_nxt       = idx_r + 7'd1;
        if (ptr_end) begin
          idx_nxt     = '0;
          cmp_ret_nxt = loop_ret_r;
          state_nxt   = S_CINIT;
        end else begin
          state_nxt = S_PAD_RD;
        end
      end
      S_CINIT: begin
        cmd.comp_init = 1'b1;
        rnd_nxt       = '0;
        state_nxt     = S_COMP;
      end
      S_COMP: begin
        cmd.comp_round = 1'b1;
        rnd_nxt        = rnd_r + 7'd1;
        if (rnd_r == last_rnd) begin
          state_nxt = S_CADD;
        end
      end
      S_CADD: begin
        cmd.comp_add = 1'b1;
        state_nxt    = cmp_ret_r;
      end
      S_FIN_MARK: begin
        cmd.wr_byte = 1'b1;
        cmd.src     = SRC_MARK;
        if (ptr_end) begin
          wrap_nxt    = 1'b0;
          cmp_ret_nxt = S_FIN_ZERO;
          state_nxt   = S_CINIT;
        end else begin
          wrap_nxt  = (stat.ptr >= PTR_LENGTH);
          state_nxt = S_FIN_ZERO;
        end
      end
      S_FIN_ZERO: begin
        if (wrap_r) begin
          cmd.wr_byte = 1'b1;
          if (ptr_end) begin
            wrap_nxt    = 1'b0;
            cmp_ret_nxt = S_FIN_ZERO;
            state_nxt   = S_CINIT;
          end
        end else if (stat.ptr == PTR_LENGTH) begin
          state_nxt = S_FIN_LEN;
        end else begin
          cmd.wr_byte = 1'b1;
        end
      end
      S_FIN_LEN: begin
        cmd.wr_byte = 1'b1;
        cmd.src     = SRC_LEN;
        if (ptr_end) begin
          cmp_ret_nxt = fin_ret_r;
          state_nxt   = S_CINIT;
        end
      end
      S_KEYDIG: begin
        cmd.key_wr     = 1'b1;
        cmd.key_wr_dig = 1'b1;
        cmd.key_addr   = idx_r[5:0];
        idx_nxt        = idx_r + 7'd1;
        if (idx_r == dig_n - 7'd1) begin
          idx_nxt       = '0;
          key_count_nxt = dig_n;
          long_nxt      = 1'b0;
          state_nxt     = S_START_IPAD;
        end
      end
      S_START_IPAD: begin
        cmd.start    = 1'b1;
        pad_nxt      = PAD_IN;
        idx_nxt      = '0;
        loop_ret_nxt = S_SET_MSG;
        state_nxt    = S_PAD_RD;
      end
      S_SET_MSG: begin
        phase_nxt = PH_MSG;
        state_nxt = S_IDLE;
      end
      S_SAVE_INNER: begin
        cmd.save_inner = 1'b1;
        cmd.start      = 1'b1;
        pad_nxt        = PAD_OUT;
        idx_nxt        = '0;
        loop_ret_nxt   = S_INNER_ABS;
        state_nxt      = S_PAD_RD;
      end
      S_INNER_ABS: begin
        cmd.wr_byte   = 1'b1;
        cmd.count_len = 1'b1;
        cmd.src       = SRC_INNER;
        idx_nxt       = idx_r + 7'd1;
        if (idx_r == dig_n - 7'd1) begin
          idx_nxt     = '0;
          fin_ret_nxt = S_OUT;
          state_nxt   = S_FIN_MARK;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 7'd1;
          if (idx_r == last_word) begin
            idx_nxt       = '0;
            phase_nxt     = PH_KEY;
            key_count_nxt = '0;
            long_nxt      = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loop_ret_r  <= S_IDLE;
      fin_ret_r   <= S_IDLE;
      cmp_ret_r   <= S_IDLE;
      pad_r       <= PAD_NONE;
      phase_r     <= PH_KEY;
      long_r      <= 1'b0;
      sha_r       <= 1'b0;
      wrap_r      <= 1'b0;
      key_count_r <= '0;
      idx_r       <= '0;
      rnd_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      loop_ret_r  <= loop_ret_nxt;
      fin_ret_r   <= fin_ret_nxt;
      cmp_ret_r   <= cmp_ret_nxt;
      pad_r       <= pad_nxt;
      phase_r     <= phase_nxt;
      long_r      <= long_nxt;
      sha_r       <= sha_nxt;
      wrap_r      <= wrap_nxt;
      key_count_r <= key_count_nxt;
      idx_r       <= idx_nxt;
      rnd_r       <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule
